// File: design/ktt_pkg.sv
package ktt_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED  = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  typedef struct packed {
    logic [3:0]  etype;
    logic [31:0] ekey;
    logic [31:0] due;
  } entry_t;

endpackage

// File: design/keyed_timer_table.sv
// A request is accepted only while idle and runs through the slot scan and the finish state;
// busy is high through both and drops as the final result appears. A new request is taken
// only after the last one is through; the pace is set by the slot scan through the single read
// port of the entry memory, one slot per cycle, with one shared 32-bit adder. A tick gives one
// result strobe per released timer, the last one at the end, or a single ST_NONE strobe if none.
// Reset (synchronous, rst_n low) empties the table and clears the millisecond counter;
// results cannot be stalled by the receiver.
module keyed_timer_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_task_type,
  input  logic [31:0] in_key_id,
  input  logic [30:0] in_delay,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_type,
  output logic [31:0] out_id,
  output logic [30:0] out_remaining,
  output logic        out_last
);

  import ktt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW:0] LAST_CNT = (AW + 1)'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [AW:0]            cnt_r, cnt_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [31:0]            now_r, now_nxt;

  logic [1:0]             mode_r, mode_nxt;
  logic [3:0]             type_r, type_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [30:0]            delay_r, delay_nxt;

  logic                   match_fnd_r, match_fnd_nxt;
  logic [AW-1:0]          match_idx_r, match_idx_nxt;
  logic [31:0]            match_due_r, match_due_nxt;
  logic                   free_fnd_r, free_fnd_nxt;
  logic [AW-1:0]          free_idx_r, free_idx_nxt;

  logic                   held_vld_r, held_vld_nxt;
  logic [3:0]             held_type_r, held_type_nxt;
  logic [31:0]            held_id_r, held_id_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic [3:0]             out_type_r, out_type_nxt;
  logic [31:0]            out_id_r, out_id_nxt;
  logic [30:0]            out_rem_r, out_rem_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   rd_en;
  entry_t                 rd_entry;
  logic                   wr_en;
  entry_t                 wr_entry;

  logic [31:0]            add_a, add_b, add_sum;
  logic                   add_ci;
  logic                   sum_due;
  logic                   slot_valid;
  logic                   key_hit;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign rd_en  = (state_r == S_SCAN) && (cnt_r != LAST_CNT);

  ktt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  // The one adder serves the due test of every slot, the remaining time of a find
  // and the due time of an insert.
  always_comb begin
    if (state_r == S_FINISH && mode_r == MODE_INSERT) begin
      add_a  = now_r;
      add_b  = {1'b0, delay_r};
      add_ci = 1'b0;
    end else if (state_r == S_FINISH) begin
      add_a  = match_due_r;
      add_b  = ~now_r;
      add_ci = 1'b1;
    end else begin
      add_a  = rd_entry.due;
      add_b  = ~now_r;
      add_ci = 1'b1;
    end
  end

  assign add_sum = add_a + add_b + {31'd0, add_ci};
  assign sum_due = (add_sum == 32'd0) || add_sum[31];

  assign slot_valid = valid_r[cmp_idx_r];
  assign key_hit    = slot_valid && (rd_entry.etype == type_r) && (rd_entry.ekey == key_r);

  assign wr_entry.etype = type_r;
  assign wr_entry.ekey  = key_r;
  assign wr_entry.due   = add_sum;
  assign wr_en = (state_r == S_FINISH) && (mode_r == MODE_INSERT) && !match_fnd_r &&
                 free_fnd_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cnt_r[AW-1:0];
    valid_nxt      = valid_r;
    now_nxt        = now_r;
    mode_nxt       = mode_r;
    type_nxt       = type_r;
    key_nxt        = key_r;
    delay_nxt      = delay_r;
    match_fnd_nxt  = match_fnd_r;
    match_idx_nxt  = match_idx_r;
    match_due_nxt  = match_due_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    held_vld_nxt   = held_vld_r;
    held_type_nxt  = held_type_r;
    held_id_nxt    = held_id_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_type_nxt   = out_type_r;
    out_id_nxt     = out_id_r;
    out_rem_nxt    = out_rem_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt     = S_SCAN;
          cnt_nxt       = '0;
          mode_nxt      = in_mode;
          type_nxt      = in_task_type;
          key_nxt       = in_key_id;
          delay_nxt     = in_delay;
          match_fnd_nxt = 1'b0;
          free_fnd_nxt  = 1'b0;
          held_vld_nxt  = 1'b0;
          if (in_mode == MODE_TICK) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r != LAST_CNT) begin
          cnt_nxt     = cnt_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
        if (cmp_vld_r) begin
          if (mode_r == MODE_TICK) begin
            if (slot_valid && sum_due) begin
              // A released timer is held back until the next one or the finish so the final one can carry last.
              valid_nxt[cmp_idx_r] = 1'b0;
              if (held_vld_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EXPIRED;
                out_type_nxt   = held_type_r;
                out_id_nxt     = held_id_r;
                out_rem_nxt    = '0;
                out_last_nxt   = 1'b0;
              end
              held_vld_nxt  = 1'b1;
              held_type_nxt = rd_entry.etype;
              held_id_nxt   = rd_entry.ekey;
            end
          end else begin
            if (key_hit && !match_fnd_r) begin
              match_fnd_nxt = 1'b1;
              match_idx_nxt = cmp_idx_r;
              match_due_nxt = rd_entry.due;
            end
            if (!slot_valid && !free_fnd_r) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = cmp_idx_r;
            end
          end
        end
      end
      S_FINISH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_type_nxt  = type_r;
        out_id_nxt    = key_r;
        out_rem_nxt   = '0;
        unique case (mode_r)
          MODE_INSERT: begin
            if (match_fnd_r) begin
              out_status_nxt = ST_DUP;
            end else if (free_fnd_r) begin
              out_status_nxt        = ST_OK;
              valid_nxt[free_idx_r] = 1'b1;
            end else begin
              out_status_nxt = ST_FULL;
            end
          end
          MODE_DELETE: begin
            if (match_fnd_r) begin
              out_status_nxt         = ST_OK;
              valid_nxt[match_idx_r] = 1'b0;
            end else begin
              out_status_nxt = ST_NOTFOUND;
            end
          end
          MODE_FIND: begin
            if (match_fnd_r) begin
              out_status_nxt = ST_OK;
              out_rem_nxt    = sum_due ? 31'd0 : add_sum[30:0];
            end else begin
              out_status_nxt = ST_NOTFOUND;
            end
          end
          default: begin
            if (held_vld_r) begin
              out_status_nxt = ST_EXPIRED;
              out_type_nxt   = held_type_r;
              out_id_nxt     = held_id_r;
            end else begin
              out_status_nxt = ST_NONE;
              out_type_nxt   = '0;
              out_id_nxt     = '0;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      now_r       <= '0;
      held_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      held_vld_r  <= held_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    mode_r       <= mode_nxt;
    type_r       <= type_nxt;
    key_r        <= key_nxt;
    delay_r      <= delay_nxt;
    match_fnd_r  <= match_fnd_nxt;
    match_idx_r  <= match_idx_nxt;
    match_due_r  <= match_due_nxt;
    free_fnd_r   <= free_fnd_nxt;
    free_idx_r   <= free_idx_nxt;
    held_type_r  <= held_type_nxt;
    held_id_r    <= held_id_nxt;
    out_status_r <= out_status_nxt;
    out_type_r   <= out_type_nxt;
    out_id_r     <= out_id_nxt;
    out_rem_r    <= out_rem_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_type      = out_type_r;
  assign out_id        = out_id_r;
  assign out_remaining = out_rem_r;
  assign out_last      = out_last_r;

  // No slot comparison may be pending once the block reports idle.
  a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmp_vld_r)
    else $error("slot compare pending while idle");

  // Expired entries are only ever reported for a tick request.
  a_expired_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EXPIRED) |-> (mode_r == MODE_TICK))
    else $error("expired result outside a tick");

  // The final result of a request is followed by a quiet cycle.
  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result right after the final one");

  // A result without the last marker is only produced during a tick scan.
  a_not_last_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == S_SCAN || state_r == S_FINISH))
    else $error("intermediate result outside a scan");

endmodule

// File: design/ktt_ram.sv
module ktt_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
